// ===== rtl/r2dif_pkg.sv =====
// Shared constants, types, twiddle table and helper functions for the radix-2 DIF FFT core.
package r2dif_pkg;

    localparam int LENGTH    = 256;
    localparam int STAGES    = 8;
    localparam int SAMPLE_W  = 16;
    localparam int TW_W      = 16;
    localparam int OUT_W     = 24;
    localparam int INDEX_W   = 8;
    localparam int DLY_W     = OUT_W + 1;           // difference before twiddle
    localparam int WIDE_W    = OUT_W + 3;           // headroom before saturation
    localparam int PROD_W    = DLY_W + TW_W;
    localparam int TW_DEPTH  = LENGTH / 2;
    localparam int TW_IDX_W  = STAGES - 1;
    localparam int STG_IDX_W = $clog2(STAGES);
    localparam int WSEL_W    = $clog2(OUT_W + 1);
    localparam int TW_FRAC   = TW_W - 1;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam longint unsigned COS_DIV [10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};
    localparam longint unsigned SIN_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

    typedef logic [2*TW_W-1:0] tw_pair_t;
    typedef tw_pair_t tw_tab_t [TW_DEPTH];

    // Q30 value to signed twiddle code, rounded half away from zero
    function automatic logic [TW_W-1:0] q30_to_tw(longint v);
        longint unsigned m;
        longint          r;
        longint          maxc;
        maxc = (longint'(1) <<< TW_FRAC) - 1;
        m = (v < 0) ? longint'(-v) : longint'(v);
        if (m > Q30_ONE)
            m = Q30_ONE;
        r = longint'((m + (64'd1 << (30 - TW_FRAC - 1))) >> (30 - TW_FRAC));
        if (v < 0)
            r = -r;
        else if (r > maxc)
            r = maxc;
        return r[TW_W-1:0];
    endfunction

    function automatic tw_tab_t build_twiddles();
        tw_tab_t         tab;
        longint unsigned u;
        longint unsigned q;
        longint unsigned rr;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned tc;
        longint unsigned ts;
        longint          sc;
        longint          ss;
        longint          cs;
        longint          sn;
        logic [TW_W-1:0] wr;
        logic [TW_W-1:0] wi;
        for (int k = 0; k < TW_DEPTH; k++) begin
            u  = 64'd4 * longint'(k);
            q  = (u / LENGTH) & 64'd3;
            rr = u % LENGTH;
            x  = (HALF_PI_Q30 * rr) / LENGTH;
            x2 = (x * x) >> 30;
            tc = Q30_ONE;
            ts = x;
            sc = longint'(tc);
            ss = longint'(ts);
            for (int n = 1; n <= 10; n++) begin
                tc = ((tc * x2) >> 30) / COS_DIV[n-1];
                ts = ((ts * x2) >> 30) / SIN_DIV[n-1];
                if ((n % 2) == 1) begin
                    sc = sc - longint'(tc);
                    ss = ss - longint'(ts);
                end
                else begin
                    sc = sc + longint'(tc);
                    ss = ss + longint'(ts);
                end
            end
            case (q)
                64'd0:   begin cs = sc;  sn = ss;  end
                64'd1:   begin cs = -ss; sn = sc;  end
                64'd2:   begin cs = -sc; sn = -ss; end
                default: begin cs = ss;  sn = -sc; end
            endcase
            wr = q30_to_tw(cs);
            wi = q30_to_tw(-sn);
            tab[k] = {wr, wi};
        end
        return tab;
    endfunction

    localparam tw_tab_t TW_TABLE = build_twiddles();

    // saturate to w bits (w <= OUT_W), result sign-extended to OUT_W
    function automatic logic signed [OUT_W-1:0] sat_w(logic signed [WIDE_W-1:0] v,
                                                      logic [WSEL_W-1:0] w);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] r;
        hi = (WIDE_W'(1) << (w - WSEL_W'(1))) - WIDE_W'(1);
        lo = ~hi;
        if (v > hi)
            r = hi;
        else if (v < lo)
            r = lo;
        else
            r = v;
        return r[OUT_W-1:0];
    endfunction

    function automatic logic [STAGES-1:0] bitrev(logic [STAGES-1:0] n);
        logic [STAGES-1:0] r;
        for (int i = 0; i < STAGES; i++)
            r[i] = n[STAGES-1-i];
        return r;
    endfunction

endpackage

// ===== rtl/r2dif_cell.sv =====
// One single-path delay-feedback butterfly cell: delay line, butterfly, twiddle multiply.
module r2dif_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [r2dif_pkg::STG_IDX_W-1:0]      stage_idx,
    input  logic signed [r2dif_pkg::OUT_W-1:0]   din_re,
    input  logic signed [r2dif_pkg::OUT_W-1:0]   din_im,
    input  logic                                 first_in,
    output logic signed [r2dif_pkg::OUT_W-1:0]   dout_re,
    output logic signed [r2dif_pkg::OUT_W-1:0]   dout_im,
    output logic                                 first_out
);

    localparam int CW = r2dif_pkg::STAGES;
    localparam int PW = r2dif_pkg::STAGES - 1;
    localparam int DW = r2dif_pkg::DLY_W;

    logic [CW-1:0] half;
    logic [CW-1:0] mask;
    logic [CW-1:0] cnt;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          lo_half;
    logic          armed_reg, armed_next;
    logic [r2dif_pkg::WSEL_W-1:0] wsel;

    logic [PW-1:0] ptr_reg, ptr_next;
    logic [2*DW-1:0] dly_mem [r2dif_pkg::TW_DEPTH];
    logic [2*DW-1:0] dly_q_reg;
    logic [2*DW-1:0] byp_reg;
    logic [2*DW-1:0] dly_out;
    logic [2*DW-1:0] wdata;

    logic signed [DW-1:0] a_re, a_im, c_re, c_im;
    logic signed [DW:0]   sum_re, sum_im;
    logic signed [DW-1:0] dif_re, dif_im;

    logic [CW-1:0]               k_full;
    logic [r2dif_pkg::TW_W-1:0]  tw_re_u, tw_im_u;
    logic signed [r2dif_pkg::TW_W-1:0] tw_re, tw_im;

    logic signed [r2dif_pkg::PROD_W-1:0] prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [r2dif_pkg::OUT_W-1:0]  s_re_reg, s_im_reg;
    logic                                mul_reg;
    logic                                first_p1_reg;
    logic signed [r2dif_pkg::PROD_W:0]   m_re, m_im;
    logic signed [r2dif_pkg::OUT_W-1:0]  out_re_reg, out_im_reg;
    logic                                first_out_reg;

    assign half = CW'(r2dif_pkg::TW_DEPTH >> stage_idx);
    assign mask = half | (half - CW'(1));
    assign cnt  = first_in ? '0 : cnt_reg;
    assign lo_half  = ((cnt & half) == '0);
    assign cnt_next = (cnt + CW'(1)) & mask;
    assign armed_next = (first_in | armed_reg) & ~(cnt == half);
    assign ptr_next = (CW'(ptr_reg) >= half - CW'(2)) ? '0 : ptr_reg + PW'(1);

    // stage output width grows by one bit per stage up to the output width
    always_comb
    begin
        if (32'(stage_idx) + r2dif_pkg::SAMPLE_W + 1 > r2dif_pkg::OUT_W)
            wsel = r2dif_pkg::WSEL_W'(r2dif_pkg::OUT_W);
        else
            wsel = r2dif_pkg::WSEL_W'(32'(stage_idx) + r2dif_pkg::SAMPLE_W + 1);
    end

    assign dly_out = (half == CW'(1)) ? byp_reg : dly_q_reg;
    assign a_re = dly_out[2*DW-1:DW];
    assign a_im = dly_out[DW-1:0];
    assign c_re = DW'(din_re);
    assign c_im = DW'(din_im);
    assign sum_re = (DW+1)'(a_re) + (DW+1)'(c_re);
    assign sum_im = (DW+1)'(a_im) + (DW+1)'(c_im);
    assign dif_re = a_re - c_re;
    assign dif_im = a_im - c_im;
    assign wdata  = lo_half ? {c_re, c_im} : {dif_re, dif_im};

    assign k_full = cnt << stage_idx;
    assign {tw_re_u, tw_im_u} = r2dif_pkg::TW_TABLE[k_full[r2dif_pkg::TW_IDX_W-1:0]];
    assign tw_re = tw_re_u;
    assign tw_im = tw_im_u;

    assign m_re = (r2dif_pkg::PROD_W+1)'(prr_reg) - (r2dif_pkg::PROD_W+1)'(pii_reg);
    assign m_im = (r2dif_pkg::PROD_W+1)'(pri_reg) + (r2dif_pkg::PROD_W+1)'(pir_reg);

    // delay line storage
    always_ff @(posedge clk)
    begin
        dly_q_reg        <= dly_mem[ptr_reg];
        dly_mem[ptr_reg] <= wdata;
        byp_reg          <= wdata;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prr_reg  <= a_re * tw_re;
        pii_reg  <= a_im * tw_im;
        pri_reg  <= a_re * tw_im;
        pir_reg  <= a_im * tw_re;
        s_re_reg <= r2dif_pkg::sat_w(r2dif_pkg::WIDE_W'(sum_re), wsel);
        s_im_reg <= r2dif_pkg::sat_w(r2dif_pkg::WIDE_W'(sum_im), wsel);
        mul_reg  <= lo_half;
        if (mul_reg)
        begin
            out_re_reg <= r2dif_pkg::sat_w(m_re[r2dif_pkg::TW_FRAC +: r2dif_pkg::WIDE_W], wsel);
            out_im_reg <= r2dif_pkg::sat_w(m_im[r2dif_pkg::TW_FRAC +: r2dif_pkg::WIDE_W], wsel);
        end
        else
        begin
            out_re_reg <= s_re_reg;
            out_im_reg <= s_im_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            armed_reg     <= 1'b0;
            first_p1_reg  <= 1'b0;
            first_out_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            armed_reg     <= armed_next;
            first_p1_reg  <= (first_in | armed_reg) & (cnt == half);
            first_out_reg <= first_p1_reg;
        end
    end

    assign dout_re   = out_re_reg;
    assign dout_im   = out_im_reg;
    assign first_out = first_out_reg;

endmodule

// ===== rtl/radix2_dif_fft_stream_core.sv =====
// Top level: frame gather memory, chain of DIF butterfly cells, bit-reverse reorder memory.
// Output: a result transaction is registered on the accepted sample that releases it, presented in the cycle after.
// Throughput: one sample per cycle while a frame is gathered and the output is not stalled;
//   after the last sample of a frame the input stalls while the frame is fed to the chain
//   (FEED) and until all bins of the last cell are captured (DRAIN).
// Reset: control cleared, no frame held, so the first frame gives no results; memories
//   are not cleared.
module radix2_dif_fft_stream_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [r2dif_pkg::SAMPLE_W-1:0] sample_re,
    input  logic signed [r2dif_pkg::SAMPLE_W-1:0] sample_im,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [r2dif_pkg::OUT_W-1:0]   bin_re,
    output logic signed [r2dif_pkg::OUT_W-1:0]   bin_im,
    output logic [r2dif_pkg::INDEX_W-1:0]        bin_index,
    output logic                                 frame_last
);

    localparam int CW = r2dif_pkg::STAGES;
    localparam int SW = r2dif_pkg::SAMPLE_W;
    localparam int OW = r2dif_pkg::OUT_W;

    typedef enum logic [1:0] {
        GATHER,
        FEED,
        DRAIN
    } state_t;

    state_t state_reg;

    // sample counter within the frame being gathered
    logic [CW-1:0] n_reg;
    logic          frame_ready_reg;
    logic          accept;

    // gather memory: raw samples of the current frame
    logic [2*SW-1:0] gmem [r2dif_pkg::LENGTH];
    logic [2*SW-1:0] gdata_reg;
    logic [CW-1:0]   feed_cnt_reg;
    logic            first_pulse_reg;

    // reorder memory: bins of the last frame in transform order
    logic [2*OW-1:0] rmem [r2dif_pkg::LENGTH];
    logic [2*OW-1:0] rdata_reg;
    logic [CW-1:0]   cap_cnt_reg;
    logic            cap_on_reg;
    logic            cap_we;
    logic [CW-1:0]   cap_addr;

    logic                            out_valid_reg;
    logic [r2dif_pkg::INDEX_W-1:0]   idx_reg;
    logic                            last_reg;

    // cell chain taps
    logic signed [OW-1:0] ch_re [r2dif_pkg::STAGES+1];
    logic signed [OW-1:0] ch_im [r2dif_pkg::STAGES+1];
    logic                 ch_first [r2dif_pkg::STAGES+1];

    assign in_ready = (state_reg == GATHER) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // chain input: stored sample sign-extended to the datapath width
    assign ch_re[0]    = OW'(signed'(gdata_reg[2*SW-1:SW]));
    assign ch_im[0]    = OW'(signed'(gdata_reg[SW-1:0]));
    assign ch_first[0] = first_pulse_reg;

    for (genvar s = 0; s < r2dif_pkg::STAGES; s++)
    begin : g_cell
        r2dif_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (r2dif_pkg::STG_IDX_W'(s)),
            .din_re    (ch_re[s]),
            .din_im    (ch_im[s]),
            .first_in  (ch_first[s]),
            .dout_re   (ch_re[s+1]),
            .dout_im   (ch_im[s+1]),
            .first_out (ch_first[s+1])
        );
    end

    // capture of the last cell's stream, first bin marked by the travelling pulse
    assign cap_we   = ch_first[r2dif_pkg::STAGES] || cap_on_reg;
    assign cap_addr = ch_first[r2dif_pkg::STAGES] ? '0 : cap_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
            gmem[n_reg] <= {sample_re, sample_im};
        gdata_reg <= gmem[feed_cnt_reg];
        if (cap_we)
            rmem[cap_addr] <= {ch_re[r2dif_pkg::STAGES], ch_im[r2dif_pkg::STAGES]};
        if (accept && frame_ready_reg)
        begin
            rdata_reg <= rmem[r2dif_pkg::bitrev(n_reg)];
            idx_reg   <= r2dif_pkg::INDEX_W'(n_reg);
            last_reg  <= (n_reg == CW'(r2dif_pkg::LENGTH - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= GATHER;
            n_reg           <= '0;
            frame_ready_reg <= 1'b0;
            feed_cnt_reg    <= '0;
            first_pulse_reg <= 1'b0;
            cap_cnt_reg     <= '0;
            cap_on_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            first_pulse_reg <= (state_reg == FEED) && (feed_cnt_reg == '0);

            if (accept)
                out_valid_reg <= frame_ready_reg;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cap_we)
            begin
                cap_cnt_reg <= cap_addr + CW'(1);
                cap_on_reg  <= (cap_addr != CW'(r2dif_pkg::LENGTH - 1));
            end

            case (state_reg)
                GATHER:
                begin
                    if (accept)
                    begin
                        n_reg <= n_reg + CW'(1);
                        if (n_reg == CW'(r2dif_pkg::LENGTH - 1))
                        begin
                            state_reg    <= FEED;
                            feed_cnt_reg <= '0;
                        end
                    end
                end
                FEED:
                begin
                    feed_cnt_reg <= feed_cnt_reg + CW'(1);
                    if (feed_cnt_reg == CW'(r2dif_pkg::LENGTH - 1))
                        state_reg <= DRAIN;
                end
                DRAIN:
                begin
                    if (cap_on_reg && (cap_cnt_reg == CW'(r2dif_pkg::LENGTH - 1)))
                    begin
                        state_reg       <= GATHER;
                        frame_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= GATHER;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign bin_re     = rdata_reg[2*OW-1:OW];
    assign bin_im     = rdata_reg[OW-1:0];
    assign bin_index  = idx_reg;
    assign frame_last = last_reg;

endmodule
